// ===== sv/echo_range_average_digit_scanner_defines.svh =====
// Assertion macros shared by the echo range scanner RTL.
`ifndef ECHO_RANGE_AVERAGE_DIGIT_SCANNER_DEFINES_SVH
`define ECHO_RANGE_AVERAGE_DIGIT_SCANNER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define ERADS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ERADS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/erads_pkg.sv =====
// Shared types and constants for the echo range scanner.
`timescale 1ns / 1ps

package erads_pkg;

    localparam int RING_DEPTH_DEF = 8;
    localparam int SAMPLE_W       = 8;
    localparam int GAIN_W         = 16;
    localparam int DIST_W         = 11;
    localparam int PWM_W          = 8;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd3540;
    localparam logic [DIST_W-1:0] DIST_MAX   = 11'd2047;
    localparam logic [PWM_W-1:0]  PWM_MAX    = 8'd255;

    localparam logic KIND_DIST  = 1'b0;
    localparam logic KIND_DIGIT = 1'b1;

    typedef enum logic [1:0] {
        OP_ECHO_START = 2'd0,
        OP_ECHO_END   = 2'd1,
        OP_TICK       = 2'd2,
        OP_SET        = 2'd3
    } op_t;

    typedef logic [1:0] digit_pos_t;
    typedef logic [3:0] digit_code_t;

    // Scan positions, thousands first.
    localparam digit_pos_t POS_THOUSANDS = 2'd0;
    localparam digit_pos_t POS_HUNDREDS  = 2'd1;
    localparam digit_pos_t POS_TENS      = 2'd2;
    localparam digit_pos_t POS_UNITS     = 2'd3;

    // Non-numeral digit codes.
    localparam digit_code_t CODE_MINUS = 4'd10;
    localparam digit_code_t CODE_BLANK = 4'd11;

    // Accept strobes handed to the ring unit.
    typedef struct packed {
        logic start;
        logic finish;
    } ring_cmd_t;

endpackage

// ===== sv/erads_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module erads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/erads_ring.sv =====
// Echo sample ring: stamp capture, ring RAM, running sum.
`timescale 1ns / 1ps

module erads_ring #(
    parameter int RING_DEPTH = erads_pkg::RING_DEPTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        adv,
    input  erads_pkg::ring_cmd_t                        cmd,
    input  logic [erads_pkg::SAMPLE_W-1:0]              stamp,
    output logic [erads_pkg::SAMPLE_W+$clog2(RING_DEPTH)-1:0] sum
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int SUM_W = erads_pkg::SAMPLE_W + PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [erads_pkg::SAMPLE_W-1:0] start_stamp_reg;
    logic [PTR_W-1:0]               ptr_reg;
    logic [PTR_W-1:0]               ptr_inc;
    logic [RING_DEPTH-1:0]          slot_vld_reg;
    logic                           p1_end_reg;
    logic                           p1_old_vld_reg;
    logic [PTR_W-1:0]               p1_addr_reg;
    logic [erads_pkg::SAMPLE_W-1:0] p1_diff_reg;
    logic [erads_pkg::SAMPLE_W-1:0] rd_data;
    logic [erads_pkg::SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]               sum_reg;
    logic [SUM_W-1:0]               sum_next;
    logic                           commit;

    assign ptr_inc    = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign commit     = adv && p1_end_reg;
    // never-written slots read as zero
    assign old_sample = p1_old_vld_reg ? rd_data : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(p1_diff_reg);
    assign sum        = sum_reg;

    erads_ram #(
        .WIDTH(erads_pkg::SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (commit),
        .waddr(p1_addr_reg),
        .wdata(p1_diff_reg),
        .re   (cmd.finish),
        .raddr(ptr_inc),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_stamp_reg <= '0;
            ptr_reg         <= '0;
            slot_vld_reg    <= '0;
            p1_end_reg      <= 1'b0;
            sum_reg         <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                start_stamp_reg <= stamp;
            end
            if (cmd.finish)
            begin
                ptr_reg <= ptr_inc;
            end
            if (adv)
            begin
                p1_end_reg <= cmd.finish;
            end
            if (commit)
            begin
                sum_reg                   <= sum_next;
                slot_vld_reg[p1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            p1_addr_reg    <= ptr_inc;
            p1_diff_reg    <= stamp - start_stamp_reg;
            p1_old_vld_reg <= slot_vld_reg[ptr_inc];
        end
    end

endmodule

// ===== sv/erads_digit.sv =====
// Digit extraction: constant-reciprocal divide, then mod-10 and code select.
`timescale 1ns / 1ps

module erads_digit (
    input  logic                   clk,
    input  logic                   adv,
    input  logic signed [15:0]     v,
    input  erads_pkg::digit_pos_t  pos,
    output erads_pkg::digit_code_t code
);

    localparam logic [15:0] RECIP_1000 = 16'd33555;  // 2^25 / 1000, rounded up
    localparam logic [15:0] RECIP_100  = 16'd41944;  // 2^22 / 100, rounded up
    localparam logic [15:0] RECIP_10   = 16'd52429;  // 2^19 / 10, rounded up

    logic [14:0] mag;
    logic [15:0] recip;
    logic [30:0] prod;
    logic [14:0] q_next;
    logic        minus_next;
    logic        blank_next;
    logic [14:0] q_reg;
    logic        minus_reg;
    logic        blank_reg;
    logic [30:0] tens_prod;
    logic [11:0] tens;
    logic [3:0]  digit;

    // Stage A: magnitude divided by the place value of the position
    always_comb
    begin
        mag = v[15] ? 15'(-v) : 15'(v);
        case (pos)
            erads_pkg::POS_THOUSANDS: recip = RECIP_1000;
            erads_pkg::POS_HUNDREDS:  recip = RECIP_100;
            erads_pkg::POS_TENS:      recip = RECIP_10;
            default:                  recip = '0;
        endcase
        prod = 31'(mag) * 31'(recip);
        case (pos)
            erads_pkg::POS_THOUSANDS:
            begin
                q_next     = 15'(prod >> 25);
                minus_next = (v < -16'sd99);
            end
            erads_pkg::POS_HUNDREDS:
            begin
                q_next     = 15'(prod >> 22);
                minus_next = (v < -16'sd9) && (v >= -16'sd99);
            end
            erads_pkg::POS_TENS:
            begin
                q_next     = 15'(prod >> 19);
                minus_next = (v < 16'sd0) && (v >= -16'sd9);
            end
            default:
            begin
                q_next     = mag;
                minus_next = 1'b0;
            end
        endcase
        blank_next = (pos != erads_pkg::POS_UNITS) && (q_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg     <= q_next;
            minus_reg <= minus_next;
            blank_reg <= blank_next;
        end
    end

    // Stage B: q mod 10
    always_comb
    begin
        tens_prod = 31'(q_reg) * 31'(RECIP_10);
        tens      = 12'(tens_prod >> 19);
        digit     = 4'(q_reg - ((15'(tens) << 3) + (15'(tens) << 1)));
        if (minus_reg)
        begin
            code = erads_pkg::CODE_MINUS;
        end
        else if (blank_reg)
        begin
            code = erads_pkg::CODE_BLANK;
        end
        else
        begin
            code = digit;
        end
    end

endmodule

// ===== sv/echo_range_average_digit_scanner.sv =====
// Top level: echo range averager with a four-digit scanned display output.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | timer_stamp[7:0], new_value[22:8]          | op[1:0]
//  m_axis   | out | distance[10:0], pwm_level[18:11],          | kind[0]
//           |     | digit_position[20:19], digit_code[24:21]   |
//  cfg      | in  | cfg_wr_data = distance_gain, on cfg_wr_en  | -
//
//  One item per cycle sustained unless the stages hold; results appear
//  after ring RAM read, running-sum update, gain multiply, digit divide
//  and output register. Echo start and value set give no result.
//  The five stages move together; they hold only when the output register
//  is full and m_axis_tready is low, so s_axis_tready follows that.
//  Reset is asynchronous; the ring reads as zero through per-slot valid
//  bits, so no clearing pass is needed and items are taken at once.
`timescale 1ns / 1ps
`include "echo_range_average_digit_scanner_defines.svh"

module echo_range_average_digit_scanner #(
    parameter int RING_DEPTH = erads_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // distance_gain
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // timer_stamp[7:0], new_value[22:8]
    input  logic [1:0]  s_axis_tuser,    // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // distance, pwm_level, digit_position, digit_code
    output logic [0:0]  m_axis_tuser     // kind
);

    localparam int SUM_W  = erads_pkg::SAMPLE_W + $clog2(RING_DEPTH);
    localparam int PROD_W = SUM_W + erads_pkg::GAIN_W;

    typedef struct packed {
        logic           vld;
        erads_pkg::op_t op;
    } stage_ctl_t;

    // handshake and decode
    logic                                adv;
    logic                                acc;
    erads_pkg::op_t                      in_op;
    logic [erads_pkg::SAMPLE_W-1:0]      in_stamp;
    logic [14:0]                         in_value;
    erads_pkg::ring_cmd_t                ring_cmd;

    // control state
    logic [erads_pkg::GAIN_W-1:0]        gain_reg;
    erads_pkg::digit_pos_t               scan_reg;
    erads_pkg::digit_pos_t               scan_next;
    logic signed [15:0]                  shown_reg;
    stage_ctl_t                          ctl1_reg;
    stage_ctl_t                          ctl2_reg;
    stage_ctl_t                          ctl3_reg;
    stage_ctl_t                          ctl4_reg;
    logic                                out_vld_reg;

    // stage payload
    logic [14:0]                         val1_reg;
    logic [14:0]                         val2_reg;
    erads_pkg::digit_pos_t               pos1_reg;
    erads_pkg::digit_pos_t               pos2_reg;
    erads_pkg::digit_pos_t               pos3_reg;
    erads_pkg::digit_pos_t               pos4_reg;
    logic [erads_pkg::DIST_W-1:0]        dist3_reg;
    logic [erads_pkg::DIST_W-1:0]        dist4_reg;
    logic signed [15:0]                  v3_reg;

    // datapath
    logic [SUM_W-1:0]                    ring_sum;
    logic [PROD_W-1:0]                   scaled_prod;
    logic [SUM_W-1:0]                    scaled;
    logic [erads_pkg::DIST_W-1:0]        dist_c;
    erads_pkg::digit_code_t              digit_code;

    // output register
    logic                                out_kind_reg;
    logic [erads_pkg::DIST_W-1:0]        out_dist_reg;
    logic [erads_pkg::PWM_W-1:0]         out_pwm_reg;
    erads_pkg::digit_pos_t               out_pos_reg;
    erads_pkg::digit_code_t              out_code_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;
    assign in_op         = erads_pkg::op_t'(s_axis_tuser);
    assign in_stamp      = s_axis_tdata[7:0];
    assign in_value      = s_axis_tdata[22:8];
    assign scan_next     = scan_reg + 1'b1;

    assign ring_cmd.start  = acc && (in_op == erads_pkg::OP_ECHO_START);
    assign ring_cmd.finish = acc && (in_op == erads_pkg::OP_ECHO_END);

    erads_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .cmd  (ring_cmd),
        .stamp(in_stamp),
        .sum  (ring_sum)
    );

    // ring sum times Q16 gain, truncated, saturated
    always_comb
    begin
        scaled_prod = PROD_W'(ring_sum) * PROD_W'(gain_reg);
        scaled      = scaled_prod[PROD_W-1:erads_pkg::GAIN_W];
        if (32'(scaled) > 32'(erads_pkg::DIST_MAX))
        begin
            dist_c = erads_pkg::DIST_MAX;
        end
        else
        begin
            dist_c = erads_pkg::DIST_W'(scaled);
        end
    end

    erads_digit u_digit (
        .clk (clk),
        .adv (adv),
        .v   (v3_reg),
        .pos (pos3_reg),
        .code(digit_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= erads_pkg::GAIN_RESET;
            scan_reg    <= '0;
            shown_reg   <= 16'sd4;
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            ctl4_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                ctl1_reg.vld <= acc;
                ctl1_reg.op  <= in_op;
                ctl2_reg     <= ctl1_reg;
                ctl3_reg     <= ctl2_reg;
                ctl4_reg     <= ctl3_reg;
                out_vld_reg  <= ctl4_reg.vld &&
                                ((ctl4_reg.op == erads_pkg::OP_ECHO_END) ||
                                 (ctl4_reg.op == erads_pkg::OP_TICK));
                if (acc && (in_op == erads_pkg::OP_TICK))
                begin
                    scan_reg <= scan_next;
                end
                // shown value changes in program order at stage two
                if (ctl2_reg.vld && (ctl2_reg.op == erads_pkg::OP_ECHO_END))
                begin
                    shown_reg <= signed'(16'(dist_c));
                end
                else if (ctl2_reg.vld && (ctl2_reg.op == erads_pkg::OP_SET))
                begin
                    shown_reg <= signed'({val2_reg[14], val2_reg});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val1_reg  <= in_value;
            pos1_reg  <= scan_next;
            val2_reg  <= val1_reg;
            pos2_reg  <= pos1_reg;
            dist3_reg <= dist_c;
            v3_reg    <= shown_reg;
            pos3_reg  <= pos2_reg;
            dist4_reg <= dist3_reg;
            pos4_reg  <= pos3_reg;
            if (ctl4_reg.op == erads_pkg::OP_ECHO_END)
            begin
                out_kind_reg <= erads_pkg::KIND_DIST;
                out_dist_reg <= dist4_reg;
                out_pwm_reg  <= (dist4_reg > erads_pkg::DIST_W'(erads_pkg::PWM_MAX)) ?
                                erads_pkg::PWM_MAX : dist4_reg[erads_pkg::PWM_W-1:0];
                out_pos_reg  <= '0;
                out_code_reg <= '0;
            end
            else
            begin
                out_kind_reg <= erads_pkg::KIND_DIGIT;
                out_dist_reg <= '0;
                out_pwm_reg  <= '0;
                out_pos_reg  <= pos4_reg;
                out_code_reg <= digit_code;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {7'd0, out_code_reg, out_pos_reg, out_pwm_reg, out_dist_reg};

    // distance results carry the PWM clamp of the same distance
    `ERADS_ASSERT_NOW(a_pwm_clamp,
        m_axis_tvalid && (m_axis_tuser == erads_pkg::KIND_DIST),
        (m_axis_tdata[18:11] ==
            ((m_axis_tdata[10:0] > 11'd255) ? 8'd255 : m_axis_tdata[18:11]))
        && ((m_axis_tdata[10:0] > 11'd255) || (11'(m_axis_tdata[18:11]) == m_axis_tdata[10:0])),
        "pwm level does not match distance")
    // units digit is always a numeral
    `ERADS_ASSERT_NOW(a_units_numeral,
        m_axis_tvalid && (m_axis_tuser == erads_pkg::KIND_DIGIT) &&
            (m_axis_tdata[20:19] == erads_pkg::POS_UNITS),
        m_axis_tdata[24:21] <= 4'd9,
        "units digit is not a numeral")
    // a tick in stage four always becomes a result at the next advance
    `ERADS_ASSERT_NEXT(a_tick_result,
        adv && ctl4_reg.vld && (ctl4_reg.op == erads_pkg::OP_TICK),
        m_axis_tvalid && (m_axis_tuser == erads_pkg::KIND_DIGIT),
        "refresh tick lost in output stage")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the echo range averager and its scanned digit output.
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES = 12;      // pipeline is five deep
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // Values that sit on the digit-rule borders and the field extremes.
    localparam int EDGE_VALUES [17] = '{-999, -100, -99, -10, -9, -1, 0, 1, 9, 10,
                                        99, 100, 999, 1000, 9999, -16384, 16383};

    typedef struct packed {
        logic                             kind;
        logic [erads_pkg::DIST_W-1:0]     distance;
        logic [erads_pkg::PWM_W-1:0]      pwm_level;
        erads_pkg::digit_pos_t            position;
        erads_pkg::digit_code_t           code;
    } scan_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // timer_stamp[7:0], new_value[22:8]
    logic [1:0]  s_axis_tuser = '0;     // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // distance, pwm_level, digit_position, digit_code
    logic [0:0]  m_axis_tuser;          // kind

    echo_range_average_digit_scanner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Shadow copy of the block's state.
    logic [erads_pkg::GAIN_W-1:0]   gain_q = erads_pkg::GAIN_RESET;
    logic [erads_pkg::SAMPLE_W-1:0] start_stamp_q = '0;
    logic [erads_pkg::SAMPLE_W-1:0] ring_q [erads_pkg::RING_DEPTH_DEF] = '{default: '0};
    logic [2:0]                     ring_ptr_q = '0;
    logic signed [15:0]             shown_value_q = 16'sd4;
    erads_pkg::digit_pos_t          scan_pos_q = '0;

    scan_result_t pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int range_checked = 0;
    int digit_checked = 0;
    int error_count = 0;
    int cycle_count = 0;

    function automatic erads_pkg::digit_code_t digit_for_value(erads_pkg::digit_pos_t pos,
                                                                int v);
        int quotient;
        int rem;
        quotient = 0;
        case (pos)
            erads_pkg::POS_THOUSANDS:
            begin
                if (v < -99) return erads_pkg::CODE_MINUS;
                quotient = v / 1000;
            end
            erads_pkg::POS_HUNDREDS:
            begin
                if (v < -9 && v >= -99) return erads_pkg::CODE_MINUS;
                quotient = v / 100;
            end
            erads_pkg::POS_TENS:
            begin
                if (v < 0 && v >= -9) return erads_pkg::CODE_MINUS;
                quotient = v / 10;
            end
            default:
            begin
                // units always show, even for zero
                rem = v % 10;
                return erads_pkg::digit_code_t'(rem < 0 ? -rem : rem);
            end
        endcase
        if (quotient == 0) return erads_pkg::CODE_BLANK;
        rem = quotient % 10;
        return erads_pkg::digit_code_t'(rem < 0 ? -rem : rem);
    endfunction

    // Applies one accepted item to the shadow state and queues its result.
    function automatic void predict_item(erads_pkg::op_t op, logic [7:0] stamp,
                                         logic [14:0] raw);
        scan_result_t r;
        int unsigned ring_sum;
        logic [31:0] scaled;
        int i;
        r = '0;
        case (op)
            erads_pkg::OP_ECHO_START: start_stamp_q = stamp;
            erads_pkg::OP_ECHO_END:
            begin
                // pointer moves first, so the first echo after reset fills slot 1
                ring_ptr_q = ring_ptr_q + 3'd1;
                ring_q[ring_ptr_q] = stamp - start_stamp_q;
                ring_sum = 0;
                for (i = 0; i < erads_pkg::RING_DEPTH_DEF; i++) ring_sum += ring_q[i];
                scaled = (ring_sum * gain_q) >> 16;
                r.kind = erads_pkg::KIND_DIST;
                r.distance = (scaled > erads_pkg::DIST_MAX) ?
                             erads_pkg::DIST_MAX : scaled[erads_pkg::DIST_W-1:0];
                r.pwm_level = (r.distance > erads_pkg::PWM_MAX) ?
                              erads_pkg::PWM_MAX : r.distance[erads_pkg::PWM_W-1:0];
                shown_value_q = {5'b0, r.distance};
                pending_results.push_back(r);
            end
            erads_pkg::OP_TICK:
            begin
                scan_pos_q = scan_pos_q + 2'd1;
                r.kind = erads_pkg::KIND_DIGIT;
                r.position = scan_pos_q;
                r.code = digit_for_value(scan_pos_q, shown_value_q);
                pending_results.push_back(r);
            end
            default: shown_value_q = {raw[14], raw};
        endcase
    endfunction

    function automatic void log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Sends one item; tvalid stays high into the next call unless that call idles.
    task automatic send_item(erads_pkg::op_t op, logic [7:0] stamp, logic [14:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, stamp};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_item(op, stamp, value);
        items_sent++;
    endtask

    // Quiet the input, let every expected result out, then cover silent items.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(logic [15:0] gain);
        wait_until_idle();
        cfg_wr_data <= gain;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gain_q = gain;
    endtask

    function automatic logic [14:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return 15'(EDGE_VALUES[$urandom_range(16)]);
        if (sel < 8) return 15'(int'($urandom_range(10998)) - 999);
        return 15'($urandom_range(32767));
    endfunction

    // Mostly proper echo pairs and scan bursts, with some stray items mixed in.
    task automatic run_traffic(int n_items);
        int stop_at;
        int sel;
        int k;
        logic [7:0] t0;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            sel = $urandom_range(19);
            if (sel < 8)
            begin
                t0 = 8'($urandom_range(255));
                send_item(erads_pkg::OP_ECHO_START, t0, 15'($urandom_range(32767)));
                send_item(erads_pkg::OP_ECHO_END, t0 + 8'($urandom_range(255)),
                          15'($urandom_range(32767)));
            end
            else if (sel < 14)
            begin
                for (k = $urandom_range(4, 1); k > 0; k--)
                    send_item(erads_pkg::OP_TICK, 8'($urandom_range(255)),
                              15'($urandom_range(32767)));
            end
            else if (sel < 18)
            begin
                send_item(erads_pkg::OP_SET, 8'($urandom_range(255)), pick_value());
                for (k = $urandom_range(4, 1); k > 0; k--)
                    send_item(erads_pkg::OP_TICK, 8'($urandom_range(255)),
                              15'($urandom_range(32767)));
            end
            else
            begin
                send_item(erads_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)),
                          pick_value());
            end
        end
    endtask

    // Reset shows 4: three blanks and the units digit.
    task automatic test_reset_display();
        repeat (4) send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
    endtask

    // Wrapped stamp differences, including an end with no fresh start.
    task automatic test_echo_wrap();
        send_item(erads_pkg::OP_ECHO_START, 8'd255, 15'd0);
        send_item(erads_pkg::OP_ECHO_END,   8'd0,   15'h7fff);
        send_item(erads_pkg::OP_ECHO_START, 8'd0,   15'd0);
        send_item(erads_pkg::OP_ECHO_END,   8'd255, 15'd0);
        send_item(erads_pkg::OP_ECHO_START, 8'd100, 15'd0);
        send_item(erads_pkg::OP_ECHO_END,   8'd100, 15'd0);
        send_item(erads_pkg::OP_ECHO_END,   8'd37,  15'd0);
    endtask

    // Minus sign at the thousands, hundreds and tens positions, blanks, and values past the thousands.
    task automatic test_digit_rules();
        send_item(erads_pkg::OP_SET, 8'd0, 15'd16383);
        repeat (4) send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
        send_item(erads_pkg::OP_SET, 8'd0, 15'(-45));
        send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
        send_item(erads_pkg::OP_SET, 8'd0, 15'(-7));
        send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
        send_item(erads_pkg::OP_SET, 8'd0, 15'(-16384));
        send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
        send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
        send_item(erads_pkg::OP_SET, 8'hff, 15'd0);
        send_item(erads_pkg::OP_TICK, 8'd0, 15'd0);
    endtask

    task automatic test_back_to_back();
        write_gain(16'hffff);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_traffic(280);
    endtask

    task automatic test_sender_gaps();
        write_gain(16'h0000);
        send_idle_pct = 85;
        recv_stall_pct = 0;
        run_traffic(200);
    endtask

    task automatic test_receiver_stalls();
        write_gain(16'($urandom_range(65535)));
        send_idle_pct = 0;
        recv_stall_pct = 85;
        run_traffic(300);
    endtask

    task automatic test_both_idle();
        write_gain(erads_pkg::GAIN_RESET);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        run_traffic(300);
    endtask

    // Receiver side: random backpressure at the current stall rate.
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: each output item against the oldest prediction.
    always @(posedge clk)
    begin
        scan_result_t exp_r;
        scan_result_t act_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act_r.kind      = m_axis_tuser[0];
            act_r.distance  = m_axis_tdata[10:0];
            act_r.pwm_level = m_axis_tdata[18:11];
            act_r.position  = m_axis_tdata[20:19];
            act_r.code      = m_axis_tdata[24:21];
            if (pending_results.size() == 0)
            begin
                log_error($sformatf("unexpected result tdata=%h tuser=%h",
                                    m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.kind == erads_pkg::KIND_DIST) range_checked++;
                else digit_checked++;
                if (act_r.kind != exp_r.kind || act_r.distance != exp_r.distance ||
                    act_r.pwm_level != exp_r.pwm_level || act_r.position != exp_r.position ||
                    act_r.code != exp_r.code || m_axis_tdata[31:25] != '0)
                    log_error($sformatf(
                        "exp kind %0d dist %0d pwm %0d pos %0d code %0d / got %0d %0d %0d %0d %0d pad %h",
                        exp_r.kind, exp_r.distance, exp_r.pwm_level, exp_r.position, exp_r.code,
                        act_r.kind, act_r.distance, act_r.pwm_level, act_r.position, act_r.code,
                        m_axis_tdata[31:25]));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("echo_range_average_digit_scanner test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_display();
        test_echo_wrap();
        test_digit_rules();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        wait_until_idle();
        $display("%0d items in, %0d range and %0d digit results compared, %0d errors",
                 items_sent, range_checked, digit_checked, error_count);
        $display("gain at zero, full scale, default and random; four idle/stall mixes");
        if (error_count == 0)
            $display("echo_range_average_digit_scanner test passed");
        else
            $display("echo_range_average_digit_scanner test failed");
        $finish;
    end

endmodule
